@@ src/smbe_pkg.sv @@
// Package for the stack machine bytecode executor.
// Holds the opcodes, result status codes and the decoded command type.
// Depends on nothing; the decoder, queue, execution stage, top level and testbench import it.
package smbe_pkg;

  // Opcode byte values.
  localparam logic [7:0] OP_PUSH  = 8'hF1;
  localparam logic [7:0] OP_DUP   = 8'hF2;
  localparam logic [7:0] OP_ADD   = 8'hF3;
  localparam logic [7:0] OP_MUL   = 8'hF4;
  localparam logic [7:0] OP_READ  = 8'hF5;
  localparam logic [7:0] OP_WRITE = 8'hF6;

  // Number of immediate bytes that follow a PUSH opcode.
  localparam logic [2:0] IMM_BYTES = 3'd4;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DEPTH_W = 7;

  // Status reported with every result word.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_WRITTEN   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_HALTED    = 3'd5
  } status_e;

  // Stack operation handed from the decoder to the execution stage.
  typedef enum logic [2:0] {
    CMD_NOP     = 3'd0,
    CMD_PUSH    = 3'd1,
    CMD_DUP     = 3'd2,
    CMD_ADD     = 3'd3,
    CMD_MUL     = 3'd4,
    CMD_WRITE   = 3'd5,
    CMD_UNKNOWN = 3'd6,
    CMD_HALTED  = 3'd7
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e             op;
    logic [DATA_W-1:0]   value;
  } cmd_t;

endpackage

@@ src/smbe_in_if.sv @@
// Input channel of the stack machine bytecode executor.
// Carries one bytecode byte and the read value per word; no dependencies.
interface smbe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  code_byte;
  logic [31:0] read_value;

  modport source (output valid, output code_byte, output read_value, input ready);
  modport sink   (input valid, input code_byte, input read_value, output ready);
endinterface

@@ src/smbe_out_if.sv @@
// Result channel of the stack machine bytecode executor.
// Carries status, written value and stack depth per word; no dependencies.
interface smbe_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_value;
  logic [6:0]  stack_depth;

  modport source (output valid, output status, output out_value, output stack_depth,
                  input ready);
  modport sink   (input valid, input status, input out_value, input stack_depth,
                  output ready);
endinterface

@@ src/smbe_front.sv @@
// Decoder of the stack machine bytecode executor.
// Collects PUSH immediates, tracks the halt flag and emits commands; uses smbe_pkg.
module smbe_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  smbe_in_if.sink        byte_i,
  output logic           cmd_valid_o,
  output smbe_pkg::cmd_t cmd_o,
  input  logic           cmd_ready_i
);
  import smbe_pkg::*;

  logic [DATA_W-1:0] coll_q, coll_d;
  logic [2:0]        left_q, left_d;
  logic              halt_q, halt_d;
  logic              accept;

  // A byte is taken whenever the command queue has room.
  assign byte_i.ready = cmd_ready_i;
  assign cmd_valid_o  = byte_i.valid;
  assign accept       = byte_i.valid && cmd_ready_i;

  // Classify the byte: immediate data, opcode or a byte after a halt.
  always_comb begin
    coll_d    = coll_q;
    left_d    = left_q;
    halt_d    = halt_q;
    cmd_o.op    = CMD_NOP;
    cmd_o.value = '0;
    if (halt_q) begin
      cmd_o.op = CMD_HALTED;
    end else if (left_q != 3'd0) begin
      coll_d = {coll_q[DATA_W-9:0], byte_i.code_byte};
      left_d = left_q - 3'd1;
      if (left_q == 3'd1) begin
        cmd_o.op    = CMD_PUSH;
        cmd_o.value = coll_d;
      end
    end else begin
      case (byte_i.code_byte)
        OP_PUSH: begin
          coll_d = '0;
          left_d = IMM_BYTES;
        end
        OP_DUP:   cmd_o.op = CMD_DUP;
        OP_ADD:   cmd_o.op = CMD_ADD;
        OP_MUL:   cmd_o.op = CMD_MUL;
        OP_READ: begin
          cmd_o.op    = CMD_PUSH;
          cmd_o.value = byte_i.read_value;
        end
        OP_WRITE: cmd_o.op = CMD_WRITE;
        default: begin
          halt_d   = 1'b1;
          cmd_o.op = CMD_UNKNOWN;
        end
      endcase
    end
  end

  // Decoder state advances only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q <= '0;
      left_q <= '0;
      halt_q <= 1'b0;
    end else if (accept) begin
      coll_q <= coll_d;
      left_q <= left_d;
      halt_q <= halt_d;
    end
  end

endmodule

@@ src/smbe_cmd_fifo.sv @@
// Two-entry command queue between decoder and execution stage.
// Lets either side stall on its own; uses smbe_pkg for the command type.
module smbe_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  smbe_pkg::cmd_t push_cmd_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output smbe_pkg::cmd_t pop_cmd_o,
  input  logic           pop_ready_i
);
  import smbe_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ src/smbe_back.sv @@
// Execution stage of the stack machine bytecode executor.
// Runs one stack command per cycle on the stack memory while the result register is free or being read; uses smbe_pkg.
module smbe_back #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  smbe_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  smbe_out_if.source     result_o
);
  import smbe_pkg::*;

  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  // Stack memory; top and next entries are also cached in registers.
  logic [DATA_W-1:0] mem_q [STACK_DEPTH];
  logic [DATA_W-1:0] tos_q, tos_d, nos_q, nos_d, third_q;
  logic [SPW-1:0]    sp_q, sp_d;
  logic              mem_we;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, sum, prod, arith;
  logic              full, pop;

  // Output register.
  logic               out_valid_q;
  status_e            status_q, status_d;
  logic [DATA_W-1:0]  value_q, value_d;
  logic [DEPTH_W-1:0] depth_q;

  assign full        = (sp_q == SPW'(STACK_DEPTH));
  assign cmd_ready_o = !out_valid_q || result_o.ready;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign sum         = nos_q + tos_q;
  assign prod        = nos_q * tos_q;
  assign arith       = (cmd_i.op == CMD_ADD) ? sum : prod;
  assign rd_addr     = AW'(sp_d - SPW'(3));

  // Execute the command at the head of the queue.
  always_comb begin
    sp_d     = sp_q;
    tos_d    = tos_q;
    nos_d    = nos_q;
    mem_we   = 1'b0;
    wr_addr  = AW'(sp_q);
    wr_data  = cmd_i.value;
    status_d = ST_OK;
    value_d  = '0;
    if (pop) begin
      case (cmd_i.op)
        CMD_NOP: status_d = ST_OK;
        CMD_PUSH: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            mem_we = 1'b1;
            tos_d  = cmd_i.value;
            nos_d  = tos_q;
            sp_d   = sp_q + SPW'(1);
          end
        end
        CMD_DUP: begin
          if (sp_q == '0) begin
            status_d = ST_UNDERFLOW;
          end else if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            mem_we  = 1'b1;
            wr_data = tos_q;
            nos_d   = tos_q;
            sp_d    = sp_q + SPW'(1);
          end
        end
        CMD_ADD, CMD_MUL: begin
          if (sp_q < SPW'(2)) begin
            status_d = ST_UNDERFLOW;
          end else begin
            mem_we  = 1'b1;
            wr_addr = AW'(sp_q - SPW'(2));
            wr_data = arith;
            tos_d   = arith;
            nos_d   = third_q;
            sp_d    = sp_q - SPW'(1);
          end
        end
        CMD_WRITE: begin
          if (sp_q == '0) begin
            status_d = ST_UNDERFLOW;
          end else begin
            status_d = ST_WRITTEN;
            value_d  = tos_q;
            tos_d    = nos_q;
            nos_d    = third_q;
            sp_d     = sp_q - SPW'(1);
          end
        end
        CMD_UNKNOWN: status_d = ST_UNKNOWN;
        CMD_HALTED:  status_d = ST_HALTED;
        default:     status_d = ST_OK;
      endcase
    end
  end

  // Stack memory: one write port, one registered read of the third entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    third_q <= mem_q[rd_addr];
  end

  // Cached top entries and result payload.
  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    nos_q <= nos_d;
    if (pop) begin
      status_q <= status_d;
      value_q  <= value_d;
      depth_q  <= DEPTH_W'(sp_d);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sp_q <= sp_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.status      = status_q;
  assign result_o.out_value   = value_q;
  assign result_o.stack_depth = depth_q;

endmodule

@@ src/stack_machine_bytecode_executor.sv @@
// Stack machine bytecode executor, top level.
// Joins decoder, command queue and execution stage; uses smbe_pkg and both channels.
//
// The block takes one bytecode byte per cycle while the command queue has room and
// returns exactly one result word per byte, in order. A byte is decoded as it is
// accepted and enters a two-entry command queue; the execution stage retires one
// command per cycle into the output register while that register is free or being
// read. Each command does at most one write and one read of the stack memory; the top
// two entries live in registers and the third is read ahead from the memory. MUL uses
// a single 32 x 32 multiplier. The stack memory needs no clearing after reset; the
// block is ready once reset is released.
// After an unknown opcode every further byte reports the halted status until reset.
module stack_machine_bytecode_executor #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smbe_in_if.sink    byte_i,
  smbe_out_if.source result_o
);
  import smbe_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  smbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  smbe_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_cmd_i   (cmd),
    .push_ready_o (cmd_ready),
    .pop_valid_o  (q_valid),
    .pop_cmd_o    (q_cmd),
    .pop_ready_i  (q_ready)
  );

  smbe_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_ready_o (q_ready),
    .result_o    (result_o)
  );

  // Only a WRITE result carries a nonzero value.
  a_value_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.status != ST_WRITTEN) |-> result_o.out_value == '0)
    else $error("result value set on a word that is not a WRITE");

  // The reported depth never exceeds the stack size.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (STACK_DEPTH > 127) || (result_o.stack_depth <= 7'(STACK_DEPTH)))
    else $error("stack depth beyond the stack size");

  // A stalled result blocks the execution stage.
  a_stall_holds_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |-> !(q_valid && q_ready))
    else $error("command retired while the result register is stalled");

endmodule

@@ dv/tb_stack_machine_bytecode_executor.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the stack machine bytecode executor.
// Drives bytecode words, predicts every result word and compares them in order;
// depends on smbe_pkg, smbe_in_if, smbe_out_if and the executor top level.
module tb_stack_machine_bytecode_executor;
  import smbe_pkg::*;

  localparam int unsigned STACK_DEPTH    = 64;
  localparam int          ITEMS_PER_PASS = 190;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] rv;
  } code_word_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
    logic [6:0]  depth;
  } exec_result_t;

  typedef enum logic [1:0] {
    GEN_FILL,
    GEN_DRAIN,
    GEN_MIX
  } gen_mode_e;

  logic clk_i;
  logic rst_ni;

  smbe_in_if  byte_bus ();
  smbe_out_if res_bus ();

  stack_machine_bytecode_executor #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_bus),
    .result_o(res_bus)
  );

  // Words waiting to be offered, and results waiting to come back.
  code_word_t   code_q[$];
  exec_result_t result_q[$];
  code_word_t   next_word;
  exec_result_t want;

  // Shadow of the executor state, updated on every accepted byte.
  logic [31:0] stack_mem[STACK_DEPTH];
  int          sp;
  logic [31:0] imm_word;
  logic [2:0]  imm_left;
  logic        halted;

  // Depth as the stimulus generator expects it, used only to steer op choice.
  int gen_depth;
  int gen_imm;
  int items_made;

  int  words_offered;
  int  words_in;
  int  words_out;
  int  fail_count;
  int  idle_cycles;
  int  hold_reqs;
  int  hold_served;
  int  hold_left;
  int  status_seen[8];
  int  tx_idle_pct;
  int  rx_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Execute one byte on the shadow stack and queue the result it should give.
  task automatic exec_byte(input logic [7:0] code, input logic [31:0] rv);
    exec_result_t r;
    logic [31:0]  a;
    logic [31:0]  b;
    r.status = ST_OK;
    r.value  = '0;
    if (halted) begin
      r.status = ST_HALTED;
    end else if (imm_left != 3'd0) begin
      imm_word = {imm_word[23:0], code};
      imm_left = imm_left - 3'd1;
      if (imm_left == 3'd0) begin
        if (sp >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          stack_mem[sp] = imm_word;
          sp++;
        end
      end
    end else begin
      case (code)
        OP_PUSH: begin
          imm_word = '0;
          imm_left = IMM_BYTES;
        end
        OP_DUP: begin
          if (sp == 0) r.status = ST_UNDERFLOW;
          else if (sp >= STACK_DEPTH) r.status = ST_OVERFLOW;
          else begin
            stack_mem[sp] = stack_mem[sp-1];
            sp++;
          end
        end
        OP_ADD, OP_MUL: begin
          if (sp < 2) begin
            r.status = ST_UNDERFLOW;
          end else begin
            b = stack_mem[sp-1];
            a = stack_mem[sp-2];
            stack_mem[sp-2] = (code == OP_ADD) ? a + b : a * b;
            sp--;
          end
        end
        OP_READ: begin
          if (sp >= STACK_DEPTH) r.status = ST_OVERFLOW;
          else begin
            stack_mem[sp] = rv;
            sp++;
          end
        end
        OP_WRITE: begin
          if (sp == 0) begin
            r.status = ST_UNDERFLOW;
          end else begin
            r.value  = stack_mem[sp-1];
            r.status = ST_WRITTEN;
            sp--;
          end
        end
        default: begin
          halted   = 1'b1;
          r.status = ST_UNKNOWN;
        end
      endcase
    end
    r.depth = 7'(sp);
    result_q.insert(result_q.size(), r);
  endtask

  // Mostly random words, with the all-zero and all-one patterns mixed in.
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'h0000_0000;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Queue one word and track the depth it should leave behind.
  task automatic emit_item(input logic [7:0] code, input logic [31:0] rv);
    code_word_t w;
    w.code = code;
    w.rv   = rv;
    code_q.insert(code_q.size(), w);
    items_made++;
    if (gen_imm > 0) begin
      gen_imm--;
      if (gen_imm == 0 && gen_depth < STACK_DEPTH) gen_depth++;
    end else begin
      case (code)
        OP_PUSH:  gen_imm = 4;
        OP_DUP:   if (gen_depth >= 1 && gen_depth < STACK_DEPTH) gen_depth++;
        OP_ADD,
        OP_MUL:   if (gen_depth >= 2) gen_depth--;
        OP_READ:  if (gen_depth < STACK_DEPTH) gen_depth++;
        OP_WRITE: if (gen_depth >= 1) gen_depth--;
        default:  ;
      endcase
    end
  endtask

  // A whole operation; a push carries four immediates, often opcode-like bytes.
  task automatic emit_op(input logic [7:0] op);
    emit_item(op, pick_word());
    if (op == OP_PUSH) begin
      repeat (4) begin
        if ($urandom_range(99) < 25) emit_item(8'($urandom_range(8'hF0, 8'hFF)), pick_word());
        else emit_item(8'(pick_word()), pick_word());
      end
    end
  endtask

  function automatic logic [7:0] pick_op(input gen_mode_e m);
    int r;
    r = $urandom_range(99);
    case (m)
      GEN_FILL: begin
        if (r < 50) return OP_DUP;
        if (r < 80) return OP_READ;
        if (r < 95) return OP_PUSH;
        return (r < 98) ? OP_ADD : OP_WRITE;
      end
      GEN_DRAIN: begin
        if (r < 40) return OP_WRITE;
        if (r < 65) return OP_ADD;
        if (r < 90) return OP_MUL;
        return (r < 95) ? OP_DUP : OP_READ;
      end
      default: begin
        case ($urandom_range(5))
          0:       return OP_PUSH;
          1:       return OP_DUP;
          2:       return OP_ADD;
          3:       return OP_MUL;
          4:       return OP_READ;
          default: return OP_WRITE;
        endcase
      end
    endcase
  endfunction

  // One stretch of well-formed program: fill to the top, drain to empty, or mix.
  task automatic run_block(input gen_mode_e m);
    int n;
    n = 0;
    case (m)
      GEN_FILL: begin
        while (gen_depth < STACK_DEPTH && n < 400) begin
          emit_op(pick_op(m));
          n++;
        end
        // Pushes against a full stack.
        repeat ($urandom_range(2, 5)) begin
          case ($urandom_range(2))
            0:       emit_op(OP_DUP);
            1:       emit_op(OP_READ);
            default: emit_op(OP_PUSH);
          endcase
        end
      end
      GEN_DRAIN: begin
        while (gen_depth > 0 && n < 400) begin
          emit_op(pick_op(m));
          n++;
        end
        // Pops against an empty or nearly empty stack.
        repeat ($urandom_range(2, 5)) begin
          case ($urandom_range(4))
            0:       emit_op(OP_WRITE);
            1:       emit_op(OP_DUP);
            2:       emit_op(OP_ADD);
            3:       emit_op(OP_MUL);
            default: emit_op(OP_READ);
          endcase
        end
      end
      default: repeat ($urandom_range(10, 40)) emit_op(pick_op(m));
    endcase
  endtask

  // Sender: offers the next queued word at the falling edge once the last one is taken.
  always @(negedge clk_i) begin
    if (rst_ni && !(byte_bus.valid && words_in != words_offered)) begin
      if (code_q.size() > 0 && !($urandom_range(99) < tx_idle_pct)) begin
        next_word = code_q.pop_front();
        byte_bus.valid      <= 1'b1;
        byte_bus.code_byte  <= next_word.code;
        byte_bus.read_value <= next_word.rv;
        words_offered++;
      end else begin
        byte_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_served != hold_reqs) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= !($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Monitor: predict on every accepted byte, check every accepted result word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_bus.valid && byte_bus.ready) begin
        exec_byte(byte_bus.code_byte, byte_bus.read_value);
        words_in++;
      end
      if (res_bus.valid && res_bus.ready) begin
        words_out++;
        status_seen[res_bus.status]++;
        if (result_q.size() == 0) begin
          $error("result word with no byte pending: status %0d value %h depth %0d",
                 res_bus.status, res_bus.out_value, res_bus.stack_depth);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (res_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_bus.status);
            fail_count++;
          end
          if (res_bus.out_value !== want.value) begin
            $error("out_value: expected %h, got %h", want.value, res_bus.out_value);
            fail_count++;
          end
          if (res_bus.stack_depth !== want.depth) begin
            $error("stack_depth: expected %0d, got %0d", want.depth, res_bus.stack_depth);
            fail_count++;
          end
        end
      end
      if ((byte_bus.valid && byte_bus.ready) || (res_bus.valid && res_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus: directed opening, then four idle phases of random program, then a halt.
  initial begin
    byte_bus.valid      = 1'b0;
    byte_bus.code_byte  = '0;
    byte_bus.read_value = '0;
    res_bus.ready       = 1'b0;
    rst_ni              = 1'b0;
    sp          = 0;
    imm_word    = '0;
    imm_left    = '0;
    halted      = 1'b0;
    gen_depth   = 0;
    gen_imm     = 0;
    items_made  = 0;
    words_offered = 0;
    words_in    = 0;
    words_out   = 0;
    fail_count  = 0;
    idle_cycles = 0;
    hold_reqs   = 0;
    hold_served = 0;
    hold_left   = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (stack_mem[i]) stack_mem[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Underflow on an empty stack, then with one entry.
    emit_item(OP_WRITE, pick_word());
    emit_item(OP_DUP, pick_word());
    emit_item(OP_ADD, pick_word());
    emit_item(OP_READ, 32'hFFFF_FFFF);
    emit_item(OP_MUL, pick_word());
    emit_item(OP_ADD, pick_word());
    // Immediates that look like opcodes are plain data.
    emit_item(OP_PUSH, pick_word());
    emit_item(OP_WRITE, pick_word());
    emit_item(8'h00, pick_word());
    emit_item(8'hFF, pick_word());
    emit_item(OP_PUSH, pick_word());
    emit_item(OP_DUP, pick_word());
    emit_item(OP_MUL, pick_word());
    emit_item(OP_ADD, pick_word());
    emit_item(OP_READ, 32'h0000_0000);
    emit_item(OP_WRITE, pick_word());
    emit_item(OP_WRITE, pick_word());
    emit_op(OP_PUSH);
    emit_item(OP_WRITE, pick_word());

    for (int phase = 0; phase < 4; phase++) begin
      // No idling, sender idle, receiver stalling, then both at a lighter rate.
      tx_idle_pct  = (phase == 1) ? 67 : ((phase == 3) ? 33 : 0);
      rx_stall_pct = (phase == 2) ? 67 : ((phase == 3) ? 33 : 0);
      items_made   = 0;
      while (items_made < ITEMS_PER_PASS) begin
        case ($urandom_range(9))
          0, 1, 2: run_block(GEN_FILL);
          3, 4, 5: run_block(GEN_DRAIN);
          default: run_block(GEN_MIX);
        endcase
      end
      // Unknown opcode goes into the last phase, since only reset clears the halt.
      if (phase == 3) begin
        emit_item(($urandom_range(1)) ? 8'($urandom_range(8'h00, 8'hF0))
                                      : 8'($urandom_range(8'hF7, 8'hFF)), pick_word());
        repeat (6) emit_op(pick_op(GEN_MIX));
      end
      // The result channel backs up while the sender keeps offering.
      if (phase == 0) hold_reqs++;
      while (code_q.size() != 0 || words_in != words_offered || result_q.size() != 0)
        @(posedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d bytes through four idle phases and a %0d-cycle result hold-off.",
             words_in, HOLD_CYCLES);
    $display("Results: %0d ok, %0d written, %0d underflow, %0d overflow, %0d unknown, %0d halted.",
             status_seen[ST_OK], status_seen[ST_WRITTEN], status_seen[ST_UNDERFLOW],
             status_seen[ST_OVERFLOW], status_seen[ST_UNKNOWN], status_seen[ST_HALTED]);
    if (fail_count == 0 && result_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
